/* hw/rtl/bpk_pkg.sv */
package bpk_pkg;

  localparam int ValueBits    = 32;
  localparam int MaxFieldBits = 32;
  // effective count limit: the field width caps the clamp as well
  localparam logic [5:0] CountLimit =
      6'((MaxFieldBits < ValueBits) ? MaxFieldBits : ValueBits);

  localparam logic [16:0] CapacityReset = 17'h10000;
  localparam logic [7:0]  TopBit        = 8'h80;

  typedef enum logic [1:0] {
    CmdAppend  = 2'd0,
    CmdPad     = 2'd1,
    CmdRestart = 2'd2
  } cmd_e;

  // one unit of work for the output side: up to four bytes or a rejection
  typedef struct packed {
    logic [31:0] data;      // first byte in the top bits
    logic [2:0]  nbytes;    // 1 to 4
    logic [15:0] index;     // stream position of the first byte
    logic        rejected;
  } job_t;

endpackage

/* hw/rtl/msb_first_bit_packer.sv */
// Channel | Dir | Transaction                | Payload
// s_axis  | in  | tvalid && tready           | tdata: value, count, pad fill; tuser: cmd
// m_axis  | out | tvalid && tready           | tdata: byte, index; tlast; tuser: reject
// cfg     | in  | cfg_valid_i && cfg_ready_o | cfg_data_i: capacity in bytes
//
// In the cycle an item is taken the front end updates the bit state and queues any job.
// The first result of an item passes the job queue and the back-end output register.
// The output side sends one byte per cycle unless m_axis stalls, up to four per append;
// sustained rate is bound by that byte-wide result channel.
// The two-entry job queue (head included while its bytes go out) absorbs two jobs;
// tready is low whenever the queue is full, until the back end pops the head job.
// Reset: empty stream, capacity 65536 bytes. No clearing pass.
module msb_first_bit_packer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [31:0] field_value, [37:32] bit_count, [38] pad_with_ones, [39] zero
  input  logic [39:0] s_axis_tdata,
  // [1:0] command
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] out_byte, [23:8] byte_index
  output logic [23:0] m_axis_tdata,
  output logic        m_axis_tlast,
  // [0] rejected
  output logic        m_axis_tuser,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [16:0] cfg_data_i
);
  import bpk_pkg::*;

  logic take;
  logic push, pop, empty, full;
  job_t job_in, job_head;
  logic [7:0]  out_byte;
  logic [15:0] out_index;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = !full;
  assign take          = s_axis_tvalid && !full;

  bpk_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_data_i      (cfg_data_i),
    .take_i          (take),
    .command_i       (s_axis_tuser),
    .field_value_i   (s_axis_tdata[31:0]),
    .bit_count_i     (s_axis_tdata[37:32]),
    .pad_with_ones_i (s_axis_tdata[38]),
    .push_o          (push),
    .job_o           (job_in)
  );

  bpk_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (job_in),
    .pop_i   (pop),
    .rdata_o (job_head),
    .empty_o (empty),
    .full_o  (full)
  );

  bpk_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .job_i        (job_head),
    .avail_i      (!empty),
    .pop_o        (pop),
    .valid_o      (m_axis_tvalid),
    .ready_i      (m_axis_tready),
    .out_byte_o   (out_byte),
    .byte_index_o (out_index),
    .last_o       (m_axis_tlast),
    .rejected_o   (m_axis_tuser)
  );

  assign m_axis_tdata = {out_index, out_byte};

endmodule

/* hw/rtl/bpk_front.sv */
module bpk_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_valid_i,
  input  logic [16:0]   cfg_data_i,
  input  logic          take_i,
  input  logic [1:0]    command_i,
  input  logic [31:0]   field_value_i,
  input  logic [5:0]    bit_count_i,
  input  logic          pad_with_ones_i,
  output logic          push_o,
  output bpk_pkg::job_t job_o
);
  import bpk_pkg::*;

  logic [16:0] cap_q;
  logic [7:0]  partial_q, partial_d;
  logic [2:0]  pos_q, pos_d;
  logic [16:0] done_q, done_d;

  logic [5:0]  cnt;
  logic [31:0] mask;
  logic [5:0]  total;
  logic [5:0]  shamt;
  logic [39:0] merged;
  logic [2:0]  need_bytes;
  logic [17:0] need;
  logic        over;
  logic [2:0]  nfull;
  logic [7:0]  rest;
  logic [7:0]  pad_byte;

  always_comb begin
    cnt    = (bit_count_i > CountLimit) ? CountLimit : bit_count_i;
    mask   = 32'((33'd1 << cnt) - 33'd1);
    total  = {3'b000, pos_q} + cnt;
    shamt  = 6'd40 - total;
    merged = {partial_q, 32'h0} | ({8'h00, field_value_i & mask} << shamt);
    need_bytes = 3'((7'(total) + 7'd7) >> 3);
    need   = {1'b0, done_q} + 18'(need_bytes);
    over   = need > {1'b0, cap_q};
    nfull  = total[5:3];
    case (nfull)
      3'd0:    rest = merged[39:32];
      3'd1:    rest = merged[31:24];
      3'd2:    rest = merged[23:16];
      3'd3:    rest = merged[15:8];
      3'd4:    rest = merged[7:0];
      default: rest = 8'h00;
    endcase
    pad_byte = partial_q | (pad_with_ones_i ? (8'hFF >> pos_q) : 8'h00);
  end

  always_comb begin
    partial_d = partial_q;
    pos_d     = pos_q;
    done_d    = done_q;
    push_o    = 1'b0;
    job_o     = '{data: merged[39:8], nbytes: nfull, index: done_q[15:0], rejected: 1'b0};
    if (take_i) begin
      unique case (cmd_e'(command_i))
        CmdAppend: begin
          if (over) begin
            push_o = 1'b1;
            job_o  = '{data: 32'h0, nbytes: 3'd1, index: done_q[15:0], rejected: 1'b1};
          end else begin
            push_o    = nfull != 3'd0;
            partial_d = rest;
            pos_d     = total[2:0];
            done_d    = done_q + 17'(nfull);
          end
        end
        CmdPad: begin
          if (pos_q != 3'd0) begin
            push_o    = 1'b1;
            job_o     = '{data: {pad_byte, 24'h0}, nbytes: 3'd1, index: done_q[15:0],
                          rejected: 1'b0};
            partial_d = 8'h00;
            pos_d     = 3'd0;
            done_d    = done_q + 17'd1;
          end
        end
        CmdRestart: begin
          partial_d = 8'h00;
          pos_d     = 3'd0;
          done_d    = '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q     <= CapacityReset;
      partial_q <= 8'h00;
      pos_q     <= 3'd0;
      done_q    <= '0;
    end else begin
      if (cfg_valid_i) cap_q <= cfg_data_i;
      partial_q <= partial_d;
      pos_q     <= pos_d;
      done_q    <= done_d;
    end
  end

endmodule

/* hw/rtl/bpk_fifo.sv */
module bpk_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  bpk_pkg::job_t wdata_i,
  input  logic          pop_i,
  output bpk_pkg::job_t rdata_o,
  output logic          empty_o,
  output logic          full_o
);
  import bpk_pkg::*;

  job_t       slot_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;

  assign rdata_o = slot_q[rptr_q];
  assign empty_o = cnt_q == 2'd0;
  assign full_o  = cnt_q == 2'd2;

  always_ff @(posedge clk_i) begin
    if (push_i) slot_q[wptr_q] <= wdata_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push_i) wptr_q <= ~wptr_q;
      if (pop_i)  rptr_q <= ~rptr_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

endmodule

/* hw/rtl/bpk_back.sv */
module bpk_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  bpk_pkg::job_t job_i,
  input  logic          avail_i,
  output logic          pop_o,
  output logic          valid_o,
  input  logic          ready_i,
  output logic [7:0]    out_byte_o,
  output logic [15:0]   byte_index_o,
  output logic          last_o,
  output logic          rejected_o
);
  import bpk_pkg::*;

  logic        ov_q;
  logic [1:0]  k_q;
  logic [7:0]  byte_q;
  logic [15:0] idx_q;
  logic        last_q, rej_q;
  logic        load;
  logic        at_end;
  logic [7:0]  sel_byte;

  assign load   = avail_i && (!ov_q || ready_i);
  assign at_end = {1'b0, k_q} == (job_i.nbytes - 3'd1);
  assign pop_o  = load && at_end;

  always_comb begin
    case (k_q)
      2'd0:    sel_byte = job_i.data[31:24];
      2'd1:    sel_byte = job_i.data[23:16];
      2'd2:    sel_byte = job_i.data[15:8];
      default: sel_byte = job_i.data[7:0];
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= sel_byte;
      idx_q  <= job_i.index + 16'(k_q);
      last_q <= at_end;
      rej_q  <= job_i.rejected;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
      k_q  <= 2'd0;
    end else begin
      if (load) begin
        ov_q <= 1'b1;
        k_q  <= at_end ? 2'd0 : k_q + 2'd1;
      end else if (ready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  assign valid_o      = ov_q;
  assign out_byte_o   = byte_q;
  assign byte_index_o = idx_q;
  assign last_o       = last_q;
  assign rejected_o   = rej_q;

endmodule

/* hw/rtl/msb_first_bit_packer_sva.sv */
module msb_first_bit_packer_sva (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata,
  input logic        m_axis_tlast,
  input logic        m_axis_tuser
);

  // a rejection is a single, empty result
  a_reject_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tlast && m_axis_tdata[7:0] == 8'h00))
    else $error("rejection result not last or carries a byte");

  // a run continues in the very next cycle with the following stream position
  a_run_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=>
      (m_axis_tvalid && !m_axis_tuser &&
       m_axis_tdata[23:8] == 16'($past(m_axis_tdata[23:8]) + 16'd1)))
    else $error("byte run broken or index not consecutive");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast) &&
       $stable(m_axis_tuser)))
    else $error("result changed while stalled");

endmodule

bind msb_first_bit_packer msb_first_bit_packer_sva u_sva (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tuser  (m_axis_tuser)
);
